/* hw/rtl/hamming_encode_correct_assert.svh */
// Assertion macros used by the Hamming encoder/corrector top level.
`ifndef HAMMING_ENCODE_CORRECT_ASSERT_SVH
`define HAMMING_ENCODE_CORRECT_ASSERT_SVH
`ifndef SYNTHESIS
`define HEC_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> cons) \
        else $error(msg);
`define HEC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define HEC_ASSERT_IMPLY(lbl, ante, cons, msg)
`define HEC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* hw/rtl/hec_pkg.sv */
// Package with constants and position helpers for the Hamming encoder/corrector.
package hec_pkg;

    localparam int MAX_DATA_BITS = 26;

    localparam int DATA_W = 26;
    localparam int CODE_W = 31;
    localparam int POS_W  = 5;
    localparam int LEN_W  = 5;
    localparam int ADDR_W = 3;
    localparam int APB_W  = 32;

    localparam logic [LEN_W-1:0] LEN_RESET = 5'd4;

    // Register index, taken from the word address.
    localparam logic REG_DATA_LENGTH = 1'b0;

    localparam logic OP_ENCODE = 1'b0;
    localparam logic OP_DECODE = 1'b1;

    // Least r with 2^r >= m + r + 1, for m up to 63.
    function automatic logic [2:0] parity_count(input logic [5:0] m);
        int mi;
        logic [2:0] cnt;
        mi  = int'(m);
        cnt = 3'd0;
        for (int k = 0; k < 7; k++) begin
            if ((1 << k) < mi + k + 1) begin
                cnt = 3'(k + 1);
            end
        end
        return cnt;
    endfunction

    function automatic bit is_pow2(input int i);
        return (i != 0) && ((i & (i - 1)) == 0);
    endfunction

    function automatic int log2_floor(input int i);
        int res;
        res = 0;
        for (int k = 0; k < 31; k++) begin
            if ((i >> k) > 1) begin
                res = k + 1;
            end
        end
        return res;
    endfunction

    // Data bit carried by a position that is not a power of two.
    function automatic int data_index(input int i);
        return i - log2_floor(i) - 2;
    endfunction

endpackage

/* hw/rtl/hec_regs.sv */
// APB register block holding the data length setting.
module hec_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [hec_pkg::ADDR_W-1:0]  paddr,
    input  logic [hec_pkg::APB_W-1:0]   pwdata,
    output logic [hec_pkg::APB_W-1:0]   prdata,
    output logic                        pready,
    output logic [hec_pkg::LEN_W-1:0]   o_data_length
);

    logic [hec_pkg::LEN_W-1:0] r_data_length;
    logic                      wr_len;

    assign pready = 1'b1;
    assign wr_len = psel && penable && pwrite && pready
                    && (paddr[2] == hec_pkg::REG_DATA_LENGTH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data_length <= hec_pkg::LEN_RESET;
        end else if (wr_len) begin
            r_data_length <= pwdata[hec_pkg::LEN_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == hec_pkg::REG_DATA_LENGTH) begin
            prdata = hec_pkg::APB_W'(r_data_length);
        end
    end

    assign o_data_length = r_data_length;

endmodule

/* hw/rtl/hec_core.sv */
// Combinational Hamming encode and syndrome/correct logic for one item.
module hec_core #(
    parameter int MAX_DATA_BITS = hec_pkg::MAX_DATA_BITS
) (
    input  logic                        i_operation,
    input  logic [hec_pkg::DATA_W-1:0]  i_data_word,
    input  logic [hec_pkg::CODE_W-1:0]  i_received_word,
    input  logic [hec_pkg::LEN_W-1:0]   i_data_length,
    output logic [hec_pkg::CODE_W-1:0]  o_code_word,
    output logic [hec_pkg::POS_W-1:0]   o_error_position,
    output logic                        o_position_out_of_range
);

    // The length register is 5 bits, so m never exceeds 31.
    localparam int MAX_M = (MAX_DATA_BITS > 31) ? 31 : MAX_DATA_BITS;
    localparam int MAX_R = int'(hec_pkg::parity_count(6'(MAX_M)));
    localparam int N_W   = MAX_M + MAX_R;
    localparam int SYN_W = MAX_R;
    localparam int DX_W  = (N_W > hec_pkg::DATA_W) ? N_W : hec_pkg::DATA_W;
    localparam int CX_W  = (N_W > hec_pkg::CODE_W) ? N_W : hec_pkg::CODE_W;
    localparam int PX_W  = (SYN_W > hec_pkg::POS_W) ? SYN_W : hec_pkg::POS_W;

    logic [5:0]       m_sat;
    logic [2:0]       par_cnt;
    logic [5:0]       n_len;
    logic [DX_W-1:0]  data_ext;
    logic [CX_W-1:0]  rx_ext;
    logic [N_W-1:0]   in_range;
    logic [N_W-1:0]   spread;
    logic [N_W-1:0]   chk_word;
    logic [SYN_W-1:0] syn;
    logic             syn_oor;
    logic [N_W-1:0]   parity_word;
    logic [N_W-1:0]   fixed_word;
    logic [CX_W-1:0]  out_ext;
    logic [PX_W-1:0]  syn_ext;
    logic             is_dec;

    always_comb begin
        m_sat = (i_data_length > hec_pkg::LEN_W'(MAX_M)) ? 6'(MAX_M) : 6'(i_data_length);
    end

    assign par_cnt  = hec_pkg::parity_count(m_sat);
    assign n_len    = m_sat + 6'(par_cnt);
    assign data_ext = DX_W'(i_data_word);
    assign rx_ext   = CX_W'(i_received_word);
    assign is_dec   = (i_operation == hec_pkg::OP_DECODE);

    // Data bits go to the positions that are not powers of two, in order.
    always_comb begin
        for (int i = 1; i <= N_W; i++) begin
            in_range[i-1] = (7'(i) <= {1'b0, n_len});
            spread[i-1]   = 1'b0;
            if (!hec_pkg::is_pow2(i)) begin
                spread[i-1] = data_ext[hec_pkg::data_index(i)] & in_range[i-1];
            end
        end
    end

    assign chk_word = is_dec ? (rx_ext[N_W-1:0] & in_range) : spread;

    // With the parity positions still clear, the syndrome of the spread word
    // is exactly the set of parity bits to insert.
    always_comb begin
        for (int k = 0; k < SYN_W; k++) begin
            syn[k] = 1'b0;
            for (int i = 1; i <= N_W; i++) begin
                if (((i >> k) & 1) != 0) begin
                    syn[k] = syn[k] ^ chk_word[i-1];
                end
            end
        end
    end

    assign syn_oor = (7'(syn) > 7'(n_len));

    always_comb begin
        parity_word = spread;
        fixed_word  = chk_word;
        for (int i = 1; i <= N_W; i++) begin
            if (hec_pkg::is_pow2(i)) begin
                parity_word[i-1] = syn[hec_pkg::log2_floor(i)];
            end
            if (!syn_oor && (7'(syn) == 7'(i))) begin
                fixed_word[i-1] = ~chk_word[i-1];
            end
        end
    end

    assign out_ext = CX_W'(is_dec ? fixed_word : parity_word);
    assign syn_ext = PX_W'(syn);

    assign o_code_word             = out_ext[hec_pkg::CODE_W-1:0];
    assign o_error_position        = is_dec ? syn_ext[hec_pkg::POS_W-1:0] : '0;
    assign o_position_out_of_range = is_dec && syn_oor;

endmodule

/* hw/rtl/hamming_encode_correct.sv */
// Top level of the configurable-length Hamming encoder and single-error corrector.
//
//  Channel   Handshake                  Payload
//  -------   -------------------------  ---------------------------------------------
//  input     start, busy (always low)   i_operation, i_data_word, i_received_word
//  result    o_done strobe              o_code_word, o_error_position,
//                                       o_position_out_of_range
//  config    APB psel/penable/pwrite    paddr, pwdata, prdata, pready
//
// One item is taken every cycle. Its result passes the input register and then the result
// register around the parity XOR tree before it reaches the result ports.
// The reset is synchronous and clears the valid flags and the data length (to 4).
// The receiver cannot stall, so busy stays low and the pipeline never holds.
`include "hamming_encode_correct_assert.svh"

module hamming_encode_correct #(
    parameter int MAX_DATA_BITS = hec_pkg::MAX_DATA_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        i_operation,
    input  logic [hec_pkg::DATA_W-1:0]  i_data_word,
    input  logic [hec_pkg::CODE_W-1:0]  i_received_word,
    output logic                        o_done,
    output logic [hec_pkg::CODE_W-1:0]  o_code_word,
    output logic [hec_pkg::POS_W-1:0]   o_error_position,
    output logic                        o_position_out_of_range,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [hec_pkg::ADDR_W-1:0]  paddr,
    input  logic [hec_pkg::APB_W-1:0]   pwdata,
    output logic [hec_pkg::APB_W-1:0]   prdata,
    output logic                        pready
);

    logic [hec_pkg::LEN_W-1:0]  data_length;

    logic                       r_in_valid;
    logic                       r_in_op;
    logic [hec_pkg::DATA_W-1:0] r_in_data;
    logic [hec_pkg::CODE_W-1:0] r_in_rx;

    logic                       r_out_valid;
    logic [hec_pkg::CODE_W-1:0] r_out_code;
    logic [hec_pkg::POS_W-1:0]  r_out_pos;
    logic                       r_out_oor;

    logic [hec_pkg::CODE_W-1:0] n_out_code;
    logic [hec_pkg::POS_W-1:0]  n_out_pos;
    logic                       n_out_oor;

    logic                       in_is_encode;

    assign busy = 1'b0;

    hec_regs u_regs (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_data_length (data_length)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= start && !busy;
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_in_op   <= i_operation;
            r_in_data <= i_data_word;
            r_in_rx   <= i_received_word;
        end
        if (r_in_valid) begin
            r_out_code <= n_out_code;
            r_out_pos  <= n_out_pos;
            r_out_oor  <= n_out_oor;
        end
    end

    hec_core #(
        .MAX_DATA_BITS (MAX_DATA_BITS)
    ) u_core (
        .i_operation             (r_in_op),
        .i_data_word             (r_in_data),
        .i_received_word         (r_in_rx),
        .i_data_length           (data_length),
        .o_code_word             (n_out_code),
        .o_error_position        (n_out_pos),
        .o_position_out_of_range (n_out_oor)
    );

    assign o_done                  = r_out_valid;
    assign o_code_word             = r_out_code;
    assign o_error_position        = r_out_pos;
    assign o_position_out_of_range = r_out_oor;

    assign in_is_encode = r_in_valid && (r_in_op == hec_pkg::OP_ENCODE);

    `HEC_ASSERT_IMPLY(a_item_gives_result, start && !busy, ##2 o_done, "accepted item lost")
    `HEC_ASSERT_IMPLY(a_no_extra_result, !(start && !busy), ##2 !o_done, "result without item")
    `HEC_ASSERT_NEXT(a_encode_clean, in_is_encode, (r_out_pos == '0) && !r_out_oor, "bad encode")

endmodule

/* dv/tb_hamming_encode_correct.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the configurable-length Hamming encoder and corrector.
module tb_hamming_encode_correct;

    localparam int CYCLE_LIMIT     = 300000;
    localparam int ITEMS_PER_PHASE = 250;
    localparam int NUM_PHASES      = 7;
    localparam logic [hec_pkg::ADDR_W-1:0] ADDR_DATA_LENGTH =
        hec_pkg::ADDR_W'(4 * int'(hec_pkg::REG_DATA_LENGTH));

    typedef struct packed {
        logic [hec_pkg::CODE_W-1:0] code_word;
        logic [hec_pkg::POS_W-1:0]  error_position;
        logic                       out_of_range;
    } t_hec_result;

    logic                         i_clk;
    logic                         i_rst_n         = 1'b0;
    logic                         start           = 1'b0;
    logic                         i_operation     = hec_pkg::OP_ENCODE;
    logic [hec_pkg::DATA_W-1:0]   i_data_word     = '0;
    logic [hec_pkg::CODE_W-1:0]   i_received_word = '0;
    logic                         psel            = 1'b0;
    logic                         penable         = 1'b0;
    logic                         pwrite          = 1'b0;
    logic [hec_pkg::ADDR_W-1:0]   paddr           = '0;
    logic [hec_pkg::APB_W-1:0]    pwdata          = '0;
    logic                         busy;
    logic                         o_done;
    logic [hec_pkg::CODE_W-1:0]   o_code_word;
    logic [hec_pkg::POS_W-1:0]    o_error_position;
    logic                         o_position_out_of_range;
    logic [hec_pkg::APB_W-1:0]    prdata;
    logic                         pready;

    // Model copy of the data length register.
    logic [hec_pkg::LEN_W-1:0]    cfg_length = hec_pkg::LEN_RESET;
    t_hec_result                  pending_codes[$];
    int                           mismatch_count = 0;
    int                           cycle_count    = 0;
    // One item in idle_odds is followed by a gap; zero means back-to-back items.
    int                           idle_odds      = 0;

    hamming_encode_correct u_dut (
        .i_clk                   (i_clk),
        .i_rst_n                 (i_rst_n),
        .start                   (start),
        .busy                    (busy),
        .i_operation             (i_operation),
        .i_data_word             (i_data_word),
        .i_received_word         (i_received_word),
        .o_done                  (o_done),
        .o_code_word             (o_code_word),
        .o_error_position        (o_error_position),
        .o_position_out_of_range (o_position_out_of_range),
        .psel                    (psel),
        .penable                 (penable),
        .pwrite                  (pwrite),
        .paddr                   (paddr),
        .pwdata                  (pwdata),
        .prdata                  (prdata),
        .pready                  (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("hamming_encode_correct: mismatch");
            $finish;
        end
    end

    function automatic int used_length(input logic [hec_pkg::LEN_W-1:0] len);
        return (int'(len) > hec_pkg::MAX_DATA_BITS) ? hec_pkg::MAX_DATA_BITS : int'(len);
    endfunction

    function automatic int check_bits_for(input int m);
        int r;
        r = 0;
        while ((1 << r) < m + r + 1) r++;
        return r;
    endfunction

    function automatic logic [hec_pkg::CODE_W-1:0] length_mask(input int n);
        return hec_pkg::CODE_W'((64'd1 << n) - 64'd1);
    endfunction

    function automatic logic [hec_pkg::CODE_W-1:0] build_code(
        input logic [hec_pkg::DATA_W-1:0] data, input int m);
        logic [hec_pkg::CODE_W-1:0] word;
        int                         r;
        int                         n;
        int                         j;
        logic                       par;
        r    = check_bits_for(m);
        n    = m + r;
        word = '0;
        j    = 0;
        for (int i = 1; i <= n; i++) begin
            if ((i & (i - 1)) != 0) begin
                word[i-1] = data[j];
                j++;
            end
        end
        // Parity positions are still zero here, so including them is harmless.
        for (int k = 0; k < r; k++) begin
            par = 1'b0;
            for (int i = 1; i <= n; i++) begin
                if ((i & (1 << k)) != 0) par ^= word[i-1];
            end
            word[(1 << k) - 1] = par;
        end
        return word;
    endfunction

    function automatic logic [hec_pkg::POS_W-1:0] syndrome_of(
        input logic [hec_pkg::CODE_W-1:0] word, input int m);
        int   r;
        int   n;
        int   s;
        logic par;
        r = check_bits_for(m);
        n = m + r;
        s = 0;
        for (int k = 0; k < r; k++) begin
            par = 1'b0;
            for (int i = 1; i <= n; i++) begin
                if ((i & (1 << k)) != 0) par ^= word[i-1];
            end
            if (par) s |= (1 << k);
        end
        return hec_pkg::POS_W'(s);
    endfunction

    function automatic t_hec_result hamming_predict(input logic op,
                                                    input logic [hec_pkg::DATA_W-1:0] data,
                                                    input logic [hec_pkg::CODE_W-1:0] rx,
                                                    input logic [hec_pkg::LEN_W-1:0] len);
        t_hec_result                res;
        logic [hec_pkg::CODE_W-1:0] word;
        int                         m;
        int                         n;
        m   = used_length(len);
        n   = m + check_bits_for(m);
        res = '0;
        if (op == hec_pkg::OP_ENCODE) begin
            res.code_word = build_code(data, m);
        end else begin
            word               = rx & length_mask(n);
            res.error_position = syndrome_of(word, m);
            if (int'(res.error_position) > n) begin
                res.out_of_range = 1'b1;
            end else if (res.error_position != '0) begin
                word[int'(res.error_position) - 1] ^= 1'b1;
            end
            res.code_word = word;
        end
        return res;
    endfunction

    // Mostly code words with zero, one or two flipped positions; some plain noise.
    function automatic logic [hec_pkg::CODE_W-1:0] random_received(input int m);
        logic [hec_pkg::CODE_W-1:0] word;
        int                         n;
        int                         kind;
        n    = m + check_bits_for(m);
        kind = $urandom_range(0, 9);
        word = build_code(hec_pkg::DATA_W'($urandom), m);
        if (kind < 2) begin
            word = hec_pkg::CODE_W'($urandom);
        end else if (kind < 8 && n > 0) begin
            word[$urandom_range(1, n) - 1] ^= 1'b1;
        end else if (kind == 8 && n > 0) begin
            word[$urandom_range(1, n) - 1] ^= 1'b1;
            word[$urandom_range(1, n) - 1] ^= 1'b1;
        end
        if ($urandom_range(0, 3) == 0) word |= hec_pkg::CODE_W'($urandom) & ~length_mask(n);
        return word;
    endfunction

    task automatic flag_mismatch(input string what);
        $display("ERROR at cycle %0d: %s", cycle_count, what);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin
        t_hec_result want;
        if (i_rst_n && o_done) begin
            if (pending_codes.size() == 0) begin
                flag_mismatch($sformatf("result with none expected, code_word %h", o_code_word));
            end else begin
                want = pending_codes.pop_front();
                if (o_code_word !== want.code_word)
                    flag_mismatch($sformatf("code_word %h, expected %h",
                                            o_code_word, want.code_word));
                if (o_error_position !== want.error_position)
                    flag_mismatch($sformatf("error_position %0d, expected %0d",
                                            o_error_position, want.error_position));
                if (o_position_out_of_range !== want.out_of_range)
                    flag_mismatch($sformatf("position_out_of_range %b, expected %b",
                                            o_position_out_of_range, want.out_of_range));
            end
        end
    end

    // Called right after a rising edge; returns after the accepting edge or a gap.
    task automatic send_item(input logic op, input logic [hec_pkg::DATA_W-1:0] data,
                             input logic [hec_pkg::CODE_W-1:0] rx);
        start           <= 1'b1;
        i_operation     <= op;
        i_data_word     <= data;
        i_received_word <= rx;
        do @(posedge i_clk); while (busy);
        pending_codes.push_back(hamming_predict(op, data, rx, cfg_length));
        if (idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
    endtask

    // Writes the data length once the block has drained, then reads it back.
    task automatic set_length(input logic [hec_pkg::LEN_W-1:0] value);
        start <= 1'b0;
        while (pending_codes.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_DATA_LENGTH;
        pwdata  <= hec_pkg::APB_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        cfg_length = value;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== hec_pkg::APB_W'(cfg_length))
            flag_mismatch($sformatf("data_length read %h, expected %h", prdata, cfg_length));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic test_reset_length();
        send_item(hec_pkg::OP_ENCODE, '0, '0);
        send_item(hec_pkg::OP_ENCODE, '1, '0);
        send_item(hec_pkg::OP_DECODE, '0, '0);
        send_item(hec_pkg::OP_DECODE, '0, '1);
        send_item(hec_pkg::OP_DECODE, '0, build_code(26'h5, 4) ^ 31'h4);
    endtask

    task automatic test_length_extremes();
        set_length(5'd26);
        send_item(hec_pkg::OP_ENCODE, '1, '0);
        send_item(hec_pkg::OP_DECODE, '0, '1);
        // A single error in the last position gives the largest syndrome.
        send_item(hec_pkg::OP_DECODE, '0, 31'h4000_0000);
        set_length(5'd0);
        send_item(hec_pkg::OP_ENCODE, '1, '1);
        send_item(hec_pkg::OP_DECODE, '1, '1);
        set_length(5'd31);
        send_item(hec_pkg::OP_ENCODE, 26'h2AA_AAAA, '0);
        send_item(hec_pkg::OP_DECODE, '0, 31'h4000_0000);
        // With two data bits the code has five positions, so syndromes 6 and 7 overflow.
        set_length(5'd2);
        send_item(hec_pkg::OP_DECODE, '0, 31'h0000_000C);
        send_item(hec_pkg::OP_DECODE, '0, 31'h0000_001F);
        send_item(hec_pkg::OP_ENCODE, '1, '0);
        set_length(5'd1);
        send_item(hec_pkg::OP_ENCODE, 26'h1, '0);
        send_item(hec_pkg::OP_DECODE, '0, 31'h0000_0007);
        set_length(5'd27);
        send_item(hec_pkg::OP_ENCODE, '1, '0);
    endtask

    task automatic test_random_phases();
        logic [hec_pkg::LEN_W-1:0] phase_length[NUM_PHASES];
        logic                      op;
        int                        m;
        phase_length = '{5'd1, 5'd26, hec_pkg::LEN_W'($urandom_range(2, 25)), 5'd0, 5'd31,
                         hec_pkg::LEN_W'($urandom_range(0, 31)), 5'd26};
        for (int p = 0; p < NUM_PHASES; p++) begin
            set_length(phase_length[p]);
            case ($urandom_range(0, 3))
                0: idle_odds = 0;
                1: idle_odds = 2;
                2: idle_odds = 4;
                default: idle_odds = 8;
            endcase
            // The closing phase runs at full rate.
            if (p == NUM_PHASES - 1) idle_odds = 0;
            m = used_length(cfg_length);
            for (int t = 0; t < ITEMS_PER_PHASE; t++) begin
                op = $urandom_range(0, 1) ? hec_pkg::OP_DECODE : hec_pkg::OP_ENCODE;
                send_item(op, hec_pkg::DATA_W'($urandom),
                          (op == hec_pkg::OP_DECODE) ? random_received(m)
                                                     : hec_pkg::CODE_W'($urandom));
            end
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        idle_odds = 3;
        test_reset_length();
        test_length_extremes();
        test_random_phases();
        start <= 1'b0;
        while (pending_codes.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("hamming_encode_correct: match");
        end else begin
            $display("hamming_encode_correct: mismatch");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/hec_pkg.sv
hw/rtl/hec_regs.sv
hw/rtl/hec_core.sv
hw/rtl/hamming_encode_correct.sv
dv/tb_hamming_encode_correct.sv
